// File: rtl/core/jddm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_pkg
// Shared types, constants and the Q1.15 product for the drive mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

	localparam int SINE_ENTRIES_DEFAULT = 1024;
	localparam int ONE_Q15 = 32768;
	localparam int SMOOTH_GAIN_Q15 = 22938;
	localparam int DIV_STAGES = 8;
	localparam int SQRT_STAGES = 8;

	typedef enum logic [2:0] {
		REG_MIXING_MODE = 3'd0,
		REG_RESPONSE_CURVE = 3'd1,
		REG_DEAD_ZONE_LEVEL = 3'd2,
		REG_TURN_GAIN = 3'd3,
		REG_FULL_SCALE_DRIVE = 3'd4,
		REG_MIN_DRIVE = 3'd5,
		REG_FLIP_LEFT = 3'd6,
		REG_FLIP_RIGHT = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MIX_ARCADE = 2'd0,
		MIX_TANK = 2'd1,
		MIX_CAR = 2'd2,
		MIX_SMOOTH = 2'd3
	} mix_mode_t;

	typedef enum logic [1:0] {
		CURVE_LINEAR = 2'd0,
		CURVE_SQUARE = 2'd1,
		CURVE_CUBE = 2'd2,
		CURVE_SQRT = 2'd3
	} curve_t;

	typedef struct packed {
		logic              zero;
		logic signed [16:0] sin;
		logic signed [16:0] cos;
	} side_t;

	typedef struct packed {
		logic              zero;
		logic signed [16:0] sin;
		logic signed [16:0] cos;
		logic [15:0]       r;
		logic [15:0]       sq;
		logic [15:0]       cube;
	} curve_side_t;

	function automatic logic signed [20:0] qmul(input logic signed [17:0] a,
		input logic signed [17:0] b);
		logic signed [35:0] p;
		logic [35:0] pm;
		logic [20:0] r;
		p = a * b;
		pm = p[35] ? 36'(-p) : 36'(p);
		r = 21'(pm >> 15);
		return p[35] ? -$signed(r) : $signed(r);
	endfunction

endpackage

// File: rtl/core/jddm_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_div_pipe
// Pipelined restoring divider: quot = floor(diff * 32768 / den), diff <= den.
// ----------------------------------------------------------------------------
module jddm_div_pipe (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [15:0] diff,
	input  logic [15:0] den,
	output logic        out_valid,
	output logic [15:0] quot
);
	import jddm_pkg::*;

	localparam int STEPS = 16 / DIV_STAGES;

	logic [DIV_STAGES:0] vld_s;
	logic [16:0] rem_s [DIV_STAGES+1];
	logic [15:0] nb_s [DIV_STAGES+1];
	logic [15:0] q_s [DIV_STAGES+1];
	logic [15:0] den_s [DIV_STAGES+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = {2'b00, diff[15:1]};
	assign nb_s[0] = {diff[0], 15'd0};
	assign q_s[0] = '0;
	assign den_s[0] = den;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [16:0] rem_n;
		logic [15:0] nb_n;
		logic [15:0] q_n;
		always_comb begin
			logic [16:0] t;
			rem_n = rem_s[g];
			nb_n = nb_s[g];
			q_n = q_s[g];
			for (int k = 0; k < STEPS; k++) begin
				t = {rem_n[15:0], nb_n[15]};
				nb_n = {nb_n[14:0], 1'b0};
				if (t >= {1'b0, den_s[g]}) begin
					rem_n = t - {1'b0, den_s[g]};
					q_n = {q_n[14:0], 1'b1};
				end else begin
					rem_n = t;
					q_n = {q_n[14:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			rem_s[g+1] <= rem_n;
			nb_s[g+1] <= nb_n;
			q_s[g+1] <= q_n;
			den_s[g+1] <= den_s[g];
		end
	end

	assign out_valid = vld_s[DIV_STAGES];
	assign quot = q_s[DIV_STAGES];

endmodule

// File: rtl/core/jddm_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_sqrt_pipe
// Pipelined bit-pair integer square root of a 31-bit value.
// ----------------------------------------------------------------------------
module jddm_sqrt_pipe (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [30:0] value,
	output logic        out_valid,
	output logic [15:0] root
);
	import jddm_pkg::*;

	localparam int STEPS = 16 / SQRT_STAGES;

	logic [SQRT_STAGES:0] vld_s;
	logic [31:0] v_s [SQRT_STAGES+1];
	logic [31:0] res_s [SQRT_STAGES+1];

	assign vld_s[0] = in_valid;
	assign v_s[0] = {1'b0, value};
	assign res_s[0] = '0;

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		logic [31:0] v_n;
		logic [31:0] res_n;
		always_comb begin
			logic [31:0] b;
			v_n = v_s[g];
			res_n = res_s[g];
			for (int k = 0; k < STEPS; k++) begin
				b = 32'd1 << (30 - 2 * (g * STEPS + k));
				if (v_n >= res_n + b) begin
					v_n = v_n - (res_n + b);
					res_n = (res_n >> 1) + b;
				end else begin
					res_n = res_n >> 1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			v_s[g+1] <= v_n;
			res_s[g+1] <= res_n;
		end
	end

	assign out_valid = vld_s[SQRT_STAGES];
	assign root = res_s[SQRT_STAGES][15:0];

endmodule

// File: rtl/core/joystick_differential_drive_mixer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer_core
// Polar stick to left/right drive: dead zone, response curve, mixing, scaling.
//
// channel   ports                                   handshake
// request   start, busy, angle_turns, stick_magnitude  start && !busy
// result    done, left_drive, right_drive           done, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// One request per cycle; busy stays low. Each result passes through stage 1,
// the divider and square-root pipelines, the mix and scale stages and the
// output register. Reset clears the valid bits and loads register defaults.
// Results cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer_core #(
	parameter int SINE_TABLE_ENTRIES = jddm_pkg::SINE_ENTRIES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        angle_turns,
	input  logic [15:0]        stick_magnitude,
	output logic               done,
	output logic signed [15:0] left_drive,
	output logic signed [15:0] right_drive,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import jddm_pkg::*;

	localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	typedef logic [33:0] rom_t [SINE_TABLE_ENTRIES];

	function automatic logic signed [16:0] quarter_sine(input logic [31:0] t);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint sum;
		x = (64'(t) * PI_HALF_Q30) >> 30;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + longint'(term);
		if (sum < 0) sum = 0;
		sum = longint'((64'(sum) + 64'd16384) >> 15);
		if (sum > ONE_Q15) sum = ONE_Q15;
		return 17'(sum);
	endfunction

	function automatic logic signed [16:0] sine_phase(input logic [31:0] ph);
		logic [31:0] u;
		logic signed [16:0] v;
		u = {2'b00, ph[29:0]};
		case (ph[31:30])
			2'd0: v = quarter_sine(u);
			2'd1: v = quarter_sine(32'h4000_0000 - u);
			2'd2: v = -quarter_sine(u);
			default: v = -quarter_sine(32'h4000_0000 - u);
		endcase
		return v;
	endfunction

	function automatic rom_t build_rom();
		rom_t rt;
		logic [63:0] ph;
		for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
			ph = (64'(i) << 32) / 64'(SINE_TABLE_ENTRIES);
			rt[i] = {sine_phase(ph[31:0]), sine_phase(ph[31:0] + 32'h4000_0000)};
		end
		return rt;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// configuration
	logic [1:0] mode_q;
	logic [1:0] curve_q;
	logic [14:0] dz_q;
	logic [15:0] gain_q;
	logic [14:0] fsd_q;
	logic [14:0] min_q;
	logic flip_l_q;
	logic flip_r_q;
	logic [15:0] smooth_g_q;
	logic [31:0] smooth_prod;

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;
	assign smooth_prod = gain_q * 16'(SMOOTH_GAIN_Q15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MIX_ARCADE;
			curve_q <= CURVE_SQUARE;
			dz_q <= 15'd2621;
			gain_q <= 16'd22938;
			fsd_q <= 15'd255;
			min_q <= 15'd35;
			flip_l_q <= 1'b0;
			flip_r_q <= 1'b0;
			smooth_g_q <= 16'd16056;
		end else begin
			smooth_g_q <= smooth_prod[30:15];
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_MIXING_MODE: mode_q <= cfg_data[1:0];
					REG_RESPONSE_CURVE: curve_q <= cfg_data[1:0];
					REG_DEAD_ZONE_LEVEL: dz_q <= cfg_data[14:0];
					REG_TURN_GAIN: gain_q <= cfg_data;
					REG_FULL_SCALE_DRIVE: fsd_q <= cfg_data[14:0];
					REG_MIN_DRIVE: min_q <= cfg_data[14:0];
					REG_FLIP_LEFT: flip_l_q <= cfg_data[0];
					REG_FLIP_RIGHT: flip_r_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// stage 1: saturate, dead zone, table index
	logic [15:0] m_sat;
	logic [33:0] idx_prod;
	logic valid_s1;
	logic zero_s1;
	logic [15:0] diff_s1;
	logic [15:0] den_s1;
	logic [IDX_W-1:0] idx_s1;

	assign m_sat = (stick_magnitude > 16'(ONE_Q15)) ? 16'(ONE_Q15) : stick_magnitude;
	assign idx_prod = 34'(angle_turns) * 34'(SINE_TABLE_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= m_sat <= {1'b0, dz_q};
		diff_s1 <= m_sat - {1'b0, dz_q};
		den_s1 <= 16'(ONE_Q15) - {1'b0, dz_q};
		idx_s1 <= idx_prod[16+IDX_W-1:16];
	end

	// stage 2: table read
	side_t side_s2;

	always_ff @(posedge clk) begin
		side_s2.zero <= zero_s1;
		side_s2.sin <= SINE_ROM[idx_s1][33:17];
		side_s2.cos <= SINE_ROM[idx_s1][16:0];
	end

	// divider, sideband delayed to match
	logic q_valid;
	logic [15:0] q_r;
	side_t side_d [DIV_STAGES];

	jddm_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.diff     (diff_s1),
		.den      (den_s1),
		.out_valid(q_valid),
		.quot     (q_r)
	);

	assign side_d[0] = side_s2;
	for (genvar g = 1; g < DIV_STAGES; g++) begin : g_side
		always_ff @(posedge clk) begin
			side_d[g] <= side_d[g-1];
		end
	end

	// curve: square then cube, square root in parallel
	logic [31:0] sq_prod;
	logic [31:0] cube_prod;
	curve_side_t cs_c1;
	curve_side_t cs_d [SQRT_STAGES-1];
	logic root_valid;
	logic [15:0] root;

	assign sq_prod = q_r * q_r;
	assign cube_prod = cs_c1.sq * cs_c1.r;

	always_ff @(posedge clk) begin
		cs_c1.zero <= side_d[DIV_STAGES-1].zero;
		cs_c1.sin <= side_d[DIV_STAGES-1].sin;
		cs_c1.cos <= side_d[DIV_STAGES-1].cos;
		cs_c1.r <= q_r;
		cs_c1.sq <= sq_prod[30:15];
		cs_c1.cube <= '0;
	end

	always_ff @(posedge clk) begin
		cs_d[0] <= {cs_c1.zero, cs_c1.sin, cs_c1.cos, cs_c1.r, cs_c1.sq,
			cube_prod[30:15]};
	end

	for (genvar g = 1; g < SQRT_STAGES - 1; g++) begin : g_cside
		always_ff @(posedge clk) begin
			cs_d[g] <= cs_d[g-1];
		end
	end

	jddm_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.value    ({q_r[15:0], 15'd0}),
		.out_valid(root_valid),
		.root     (root)
	);

	// mix stage 1
	curve_side_t cs_e;
	logic [15:0] mag;
	logic signed [17:0] cos_abs;
	logic valid_m1;
	logic zero_m1;
	logic signed [17:0] sin_m1;
	logic signed [17:0] cos_m1;
	logic signed [17:0] mag_m1;
	logic signed [17:0] a_m1;
	logic signed [17:0] b_m1;
	logic signed [20:0] qa_m1;
	logic signed [20:0] qb_m1;

	assign cs_e = cs_d[SQRT_STAGES-2];
	assign cos_abs = cs_e.cos[16] ? -18'(cs_e.cos) : 18'(cs_e.cos);

	always_comb begin
		case (curve_t'(curve_q))
			CURVE_LINEAR: mag = cs_e.r;
			CURVE_SQUARE: mag = cs_e.sq;
			CURVE_CUBE: mag = cs_e.cube;
			default: mag = root;
		endcase
		if (mode_q == MIX_CAR) begin
			qa_m1 = qmul(cos_abs, {2'b00, gain_q});
			qb_m1 = '0;
		end else begin
			qa_m1 = qmul({2'b00, mag}, 18'(cs_e.cos));
			qb_m1 = qmul({2'b00, mag}, 18'(cs_e.sin));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_m1 <= 1'b0;
		end else begin
			valid_m1 <= root_valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_m1 <= cs_e.zero;
		sin_m1 <= 18'(cs_e.sin);
		cos_m1 <= 18'(cs_e.cos);
		mag_m1 <= {2'b00, mag};
		a_m1 <= qa_m1[17:0];
		b_m1 <= qb_m1[17:0];
	end

	// mix stage 2
	logic signed [17:0] f;
	logic signed [17:0] g_sel;
	logic signed [20:0] q_m2;
	logic valid_m2;
	logic zero_m2;
	logic signed [17:0] mag_m2;
	logic signed [17:0] l_m2;
	logic signed [17:0] r_m2;
	logic signed [17:0] y_m2;

	assign f = 18'(ONE_Q15) - a_m1;

	always_comb begin
		case (mix_mode_t'(mode_q))
			MIX_TANK: g_sel = 18'(ONE_Q15);
			MIX_SMOOTH: g_sel = {2'b00, smooth_g_q};
			default: g_sel = {2'b00, gain_q};
		endcase
		if (mode_q == MIX_CAR) q_m2 = qmul(sin_m1, f);
		else q_m2 = qmul(a_m1, g_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_m2 <= 1'b0;
		end else begin
			valid_m2 <= valid_m1;
		end
	end

	always_ff @(posedge clk) begin
		zero_m2 <= zero_m1;
		mag_m2 <= mag_m1;
		y_m2 <= b_m1;
		if (mode_q != MIX_CAR) begin
			l_m2 <= q_m2[17:0];
			r_m2 <= q_m2[17:0];
		end else if (cos_m1 > 0) begin
			l_m2 <= sin_m1;
			r_m2 <= q_m2[17:0];
		end else begin
			l_m2 <= q_m2[17:0];
			r_m2 <= sin_m1;
		end
	end

	// mix stage 3
	logic signed [20:0] car_l;
	logic signed [20:0] car_r;
	logic signed [18:0] sum_l;
	logic signed [18:0] sum_r;
	logic valid_m3;
	logic zero_m3;
	logic signed [17:0] spd_l_m3;
	logic signed [17:0] spd_r_m3;

	function automatic logic signed [17:0] clamp_one(input logic signed [18:0] v);
		logic signed [17:0] r;
		if (v > 19'sd32768) r = 18'sd32768;
		else if (v < -19'sd32768) r = -18'sd32768;
		else r = v[17:0];
		return r;
	endfunction

	assign car_l = qmul(l_m2, mag_m2);
	assign car_r = qmul(r_m2, mag_m2);
	assign sum_l = 19'(y_m2) + 19'(l_m2);
	assign sum_r = 19'(y_m2) - 19'(l_m2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_m3 <= 1'b0;
		end else begin
			valid_m3 <= valid_m2;
		end
	end

	always_ff @(posedge clk) begin
		zero_m3 <= zero_m2;
		if (mode_q == MIX_CAR) begin
			spd_l_m3 <= car_l[17:0];
			spd_r_m3 <= car_r[17:0];
		end else begin
			spd_l_m3 <= clamp_one(sum_l);
			spd_r_m3 <= clamp_one(sum_r);
		end
	end

	// scale stage
	logic signed [20:0] drv_l;
	logic signed [20:0] drv_r;
	logic valid_m4;
	logic zero_m4;
	logic signed [15:0] d_l_m4;
	logic signed [15:0] d_r_m4;

	assign drv_l = qmul(spd_l_m3, {3'b000, fsd_q});
	assign drv_r = qmul(spd_r_m3, {3'b000, fsd_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_m4 <= 1'b0;
		end else begin
			valid_m4 <= valid_m3;
		end
	end

	always_ff @(posedge clk) begin
		zero_m4 <= zero_m3;
		d_l_m4 <= drv_l[15:0];
		d_r_m4 <= drv_r[15:0];
	end

	// lift, flip, output
	function automatic logic signed [15:0] lift(input logic signed [15:0] d,
		input logic [14:0] mn, input logic flip);
		logic signed [15:0] v;
		logic signed [15:0] m;
		m = {1'b0, mn};
		v = d;
		if (d > 0 && d < m) v = m;
		else if (d < 0 && d > -m) v = -m;
		return flip ? -v : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_m4;
		end
	end

	always_ff @(posedge clk) begin
		if (zero_m4) begin
			left_drive <= '0;
			right_drive <= '0;
		end else begin
			left_drive <= lift(d_l_m4, min_q, flip_l_q);
			right_drive <= lift(d_r_m4, min_q, flip_r_q);
		end
	end

endmodule
